/* sv/lzss_delta_window_decoder_top_defines.svh */
// Assertion macros shared by the decoder's checker.
// Depends on nothing; included by sv/lzssdw_checker.sv.
`ifndef LZSS_DELTA_WINDOW_DECODER_TOP_DEFINES_SVH
`define LZSS_DELTA_WINDOW_DECODER_TOP_DEFINES_SVH

// Clocked property that is switched off while reset is asserted.
`define LZSSDW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that also holds while reset is asserted.
`define LZSSDW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/lzssdw_pkg.sv */
// Constants and codes for the LZSS delta window decoder.
// No dependencies; used by the top level and the checker.
package lzssdw_pkg;

  localparam int WINDOW_SIZE = 2048;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 24;
  localparam int LEN_W       = 5;
  localparam int MIN_MATCH   = 3;
  localparam int MAX_MATCH   = 34;
  // Bytes still to copy after the current one: up to MAX_MATCH - 1.
  localparam int REM_W       = 6;
  localparam int IN_DATA_W   = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 24;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_MODE   = 1'b1;

endpackage

/* sv/lzssdw_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; holds the decoder's history window.
module lzssdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lzss_delta_window_decoder_top.sv */
// LZSS token decoder with a 2048-byte history window and optional delta output.
// Depends on lzssdw_pkg and lzssdw_ram. Each input item is one token: a literal
// gives one output item, a match copies 3 to 34 bytes from an absolute window
// position, one output item per byte, each byte also written back at the write
// pointer. Tokens are handled one at a time; in_tready is high only when idle.
// A literal passes from acceptance through the check and emit states to the
// result register; a match passes the check state and then, for every copied
// byte, a read state for the registered window read and an emit state that
// writes it back and presents it. A token with restart set first clears
// window entries 0 to 0x7DD, and after reset the whole window is cleared
// before the first item is taken. Configuration may be written at any time
// while idle. Output stalls hold the sequencer; the result register lets a new
// token be accepted while the last byte of the previous one is still waiting.
module lzss_delta_window_decoder_top #(
  parameter int WINDOW_SIZE = lzssdw_pkg::WINDOW_SIZE
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // restart [0], literal_byte [8:1], match_word [24:9], zero fill [31:25]
  input  logic [lzssdw_pkg::IN_DATA_W-1:0]    in_tdata,
  // is_match [0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_byte [7:0]
  output logic [lzssdw_pkg::BYTE_W-1:0]       out_tdata,
  output logic                                out_tlast,
  // plane_done [0]
  output logic                                out_tuser,
  input  logic                                cfg_we,
  input  logic [lzssdw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lzssdw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0] START_POS =
      AW'(WINDOW_SIZE - lzssdw_pkg::MAX_MATCH);
  localparam logic [AW-1:0] CLR_LAST_RESTART =
      AW'(WINDOW_SIZE - lzssdw_pkg::MAX_MATCH - 1);
  localparam logic [AW-1:0] CLR_LAST_FULL = AW'(WINDOW_SIZE - 1);

  localparam int BW = lzssdw_pkg::BYTE_W;
  localparam int CW = lzssdw_pkg::COUNT_W;
  localparam int RW = lzssdw_pkg::REM_W;
  localparam int LW = lzssdw_pkg::LEN_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_READ  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic            rst_clear_r, rst_clear_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [BW-1:0]   sum_r, sum_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   limit_r, limit_nxt;
  logic            delta_r, delta_nxt;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            tok_match_r, tok_match_nxt;
  logic [BW-1:0]   tok_lit_r, tok_lit_nxt;
  logic [AW-1:0]   tok_pos_r, tok_pos_nxt;
  logic [LW-1:0]   tok_len_r, tok_len_nxt;
  logic [BW-1:0]   out_data_r, out_data_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_done_r, out_done_nxt;

  logic            in_fire;
  logic            out_load;
  logic            emit_fire;
  logic [BW-1:0]   ram_rdata;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [BW-1:0]   ram_wdata;
  logic [BW-1:0]   byte_val;
  logic [BW-1:0]   sum_inc;
  logic [CW-1:0]   count_inc;
  logic            emit_done;
  logic            emit_last;
  logic            clear_last;
  logic [AW-1:0]   addr_inc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_load   = !out_valid_r || out_tready;
  assign emit_fire  = (state_r == ST_EMIT) && out_load;

  // The single address incrementer serves both the clearing sweep and the copy.
  assign addr_inc   = addr_r + AW'(1);

  assign byte_val   = tok_match_r ? ram_rdata : tok_lit_r;
  assign sum_inc    = sum_r + byte_val;
  assign count_inc  = count_r + CW'(1);
  assign emit_done  = (count_inc >= limit_r);
  assign emit_last  = !tok_match_r || (rem_r == '0) || emit_done;
  assign clear_last = rst_clear_r ? (addr_r == CLR_LAST_RESTART)
                                  : (addr_r == CLR_LAST_FULL);

  assign ram_we    = (state_r == ST_CLEAR) || emit_fire;
  assign ram_waddr = (state_r == ST_CLEAR) ? addr_r : wp_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : byte_val;

  lzssdw_ram #(
    .WIDTH (BW),
    .DEPTH (WINDOW_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    rst_clear_nxt = rst_clear_r;
    wp_nxt        = wp_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    tok_match_nxt = tok_match_r;
    tok_lit_nxt   = tok_lit_r;
    tok_pos_nxt   = tok_pos_r;
    tok_len_nxt   = tok_len_r;

    unique case (state_r)
      ST_CLEAR: begin
        addr_nxt = addr_inc;
        if (clear_last) begin
          state_nxt = rst_clear_r ? ST_CHECK : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          tok_match_nxt = in_tuser;
          tok_lit_nxt   = in_tdata[8:1];
          tok_len_nxt   = in_tdata[13:9];
          tok_pos_nxt   = AW'(in_tdata[24:14]);
          if (in_tdata[0]) begin
            wp_nxt        = START_POS;
            sum_nxt       = '0;
            count_nxt     = '0;
            addr_nxt      = '0;
            rst_clear_nxt = 1'b1;
            state_nxt     = ST_CLEAR;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (count_r >= limit_r) begin
          state_nxt = ST_IDLE;
        end else if (tok_match_r) begin
          addr_nxt  = tok_pos_r;
          rem_nxt   = RW'(tok_len_r) + RW'(lzssdw_pkg::MIN_MATCH - 1);
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          wp_nxt    = wp_r + AW'(1);
          sum_nxt   = sum_inc;
          count_nxt = count_inc;
          addr_nxt  = addr_inc;
          rem_nxt   = rem_r - RW'(1);
          state_nxt = emit_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = delta_r ? sum_inc : byte_val;
      out_last_nxt  = emit_last;
      out_done_nxt  = emit_done;
    end
  end

  always_comb begin
    limit_nxt = limit_r;
    delta_nxt = delta_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lzssdw_pkg::CFG_OUTPUT_LIMIT: limit_nxt = cfg_wdata[CW-1:0];
        lzssdw_pkg::CFG_DELTA_MODE:   delta_nxt = cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      rst_clear_r <= 1'b0;
      wp_r        <= START_POS;
      sum_r       <= '0;
      count_r     <= '0;
      rem_r       <= '0;
      limit_r     <= lzssdw_pkg::LIMIT_RESET;
      delta_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      rst_clear_r <= rst_clear_nxt;
      wp_r        <= wp_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      limit_r     <= limit_nxt;
      delta_r     <= delta_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_match_r <= tok_match_nxt;
    tok_lit_r   <= tok_lit_nxt;
    tok_pos_r   <= tok_pos_nxt;
    tok_len_r   <= tok_len_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

/* sv/lzssdw_checker.sv */
// Port-level checker for the LZSS delta window decoder, bound to its top level.
// Depends on lzssdw_pkg and the assertion macros in the defines header.
`include "lzss_delta_window_decoder_top_defines.svh"

module lzssdw_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lzssdw_pkg::BYTE_W-1:0]     out_tdata,
  input logic                              out_tlast,
  input logic                              out_tuser
);

  // A stalled item keeps its payload.
  `LZSSDW_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "output item changed while stalled")

  // The block is busy with a token for at least the cycle after it takes it.
  `LZSSDW_ASSERT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "input ready right after accepting a token")

  // Reaching the limit always ends the token.
  `LZSSDW_ASSERT(a_done_is_last, clk, rst_n, out_tvalid && out_tuser |-> out_tlast, "plane done without last of token")

  // Reset empties the output and starts the window clear.
  `LZSSDW_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid && !in_tready, "item traffic right after reset")

endmodule

bind lzss_delta_window_decoder_top lzssdw_checker u_lzssdw_checker (.*);
